// ===== sv/wbps_pkg.sv =====
package wbps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 7;
  localparam int ADDR_W      = 32;
  localparam int POS_W       = 31;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_SCAN    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic {
    REG_PATTERN_LENGTH = 1'b0,
    REG_BASE_ADDRESS   = 1'b1
  } reg_index_t;

  // wild flag on top, byte value below
  typedef struct packed {
    logic       wild;
    logic [7:0] value;
  } entry_t;

endpackage

// ===== sv/wbps_if.sv =====
interface wbps_item_if;
  logic                     valid;
  logic                     ready;
  wbps_pkg::kind_t          kind;
  logic [wbps_pkg::IDX_W-1:0] entry_index;
  logic [7:0]               entry_value;
  logic                     entry_wild;
  logic [7:0]               data_byte;
  logic                     last_byte;

  modport source (output valid, kind, entry_index, entry_value, entry_wild,
                  data_byte, last_byte, input ready);
  modport sink   (input valid, kind, entry_index, entry_value, entry_wild,
                  data_byte, last_byte, output ready);
endinterface

interface wbps_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [wbps_pkg::ADDR_W-1:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

// ===== sv/wildcard_byte_pattern_scanner.sv =====
// Channel   Dir  Handshake     Payload
// items     in   valid/ready   kind, entry_index, entry_value, entry_wild, data_byte, last_byte
// results   out  valid/ready   found, match_address
// cfg       in   cfg_we        cfg_index, cfg_data (pattern_length, base_address)
//
// One item per cycle sustained while results are taken; an accepted item enters the input
// register, then one pass through the 64-lane compare loads the result register when that
// register is empty or its result is being taken.
// rst is synchronous: clears match vector, position, done flag and valid flags,
// sets pattern_length to 1 and base_address to 0; the pattern store is not cleared.
// A stalled result blocks processing; one item still enters the input register.
module wildcard_byte_pattern_scanner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  wbps_pkg::reg_index_t         cfg_index,
  input  logic [wbps_pkg::ADDR_W-1:0]  cfg_data,
  wbps_item_if.sink                    items,
  wbps_result_if.source                results
);

  localparam int N = wbps_pkg::MAX_PATTERN;

  // configuration
  logic [wbps_pkg::LEN_W-1:0]  pattern_length;
  logic [wbps_pkg::ADDR_W-1:0] base_address;

  // input register
  logic                        s_valid;
  wbps_pkg::kind_t             s_kind;
  logic [wbps_pkg::IDX_W-1:0]  s_index;
  wbps_pkg::entry_t            s_entry;
  logic [7:0]                  s_byte;
  logic                        s_last;

  // scan state
  wbps_pkg::entry_t            pstore [N];
  logic [N-1:0]                partial;
  logic [N-1:0]                partial_next;
  logic [wbps_pkg::POS_W-1:0]  scan_position;
  logic                        scan_done;

  // result register
  logic                        o_valid;
  logic                        o_found;
  logic [wbps_pkg::ADDR_W-1:0] o_addr;

  logic                        proc;
  logic [wbps_pkg::IDX_W-1:0]  last_idx;
  logic [N-1:0]                byte_hit;
  logic [N-1:0]                len_mask;
  logic                        hit;
  logic                        do_scan;
  logic                        emit;
  logic [wbps_pkg::ADDR_W-1:0] start_pos;
  logic [wbps_pkg::ADDR_W-1:0] addr_next;

  assign proc          = s_valid && (!o_valid || results.ready);
  assign items.ready   = !s_valid || proc;

  assign results.valid         = o_valid;
  assign results.found         = o_found;
  assign results.match_address = o_addr;

  // active length minus one, length 0 taken as 1 and clamped to the store depth
  always_comb begin
    if (pattern_length == '0) begin
      last_idx = '0;
    end else if (pattern_length > wbps_pkg::LEN_W'(N)) begin
      last_idx = wbps_pkg::IDX_W'(N - 1);
    end else begin
      last_idx = wbps_pkg::IDX_W'(pattern_length - 1'b1);
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      byte_hit[i] = pstore[i].wild || (pstore[i].value == s_byte);
      len_mask[i] = (wbps_pkg::IDX_W'(i) <= last_idx);
    end
  end

  assign partial_next = {partial[N-2:0], 1'b1} & byte_hit & len_mask;
  assign hit          = partial_next[last_idx];
  assign do_scan      = (s_kind == wbps_pkg::KIND_SCAN) && !scan_done;
  assign emit         = do_scan && (hit || s_last);
  assign start_pos    = {1'b0, scan_position} - wbps_pkg::ADDR_W'(last_idx);
  assign addr_next    = base_address + start_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= wbps_pkg::LEN_W'(1);
      base_address   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[wbps_pkg::LEN_W-1:0];
        wbps_pkg::REG_BASE_ADDRESS:   base_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (items.ready) begin
      s_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s_kind        <= items.kind;
      s_index       <= items.entry_index;
      s_entry.wild  <= items.entry_wild;
      s_entry.value <= items.entry_value;
      s_byte        <= items.data_byte;
      s_last        <= items.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s_kind == wbps_pkg::KIND_LOAD) begin
      pstore[s_index] <= s_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial       <= '0;
      scan_position <= '0;
      scan_done     <= 1'b0;
    end else if (proc) begin
      if (s_kind == wbps_pkg::KIND_RESTART) begin
        partial       <= '0;
        scan_position <= '0;
        scan_done     <= 1'b0;
      end else if (do_scan) begin
        partial <= partial_next;
        if (scan_position != wbps_pkg::POS_MAX) begin
          scan_position <= scan_position + 1'b1;
        end
        if (emit) begin
          scan_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (proc) begin
      o_valid <= emit;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      o_found <= hit;
      o_addr  <= hit ? addr_next : '0;
    end
  end

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (proc && emit) |=> scan_done)
    else $error("scan_done not set after a result");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (proc && s_kind == wbps_pkg::KIND_RESTART) |=>
      (partial == '0 && scan_position == '0 && !scan_done))
    else $error("restart left scan state behind");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !o_valid |-> items.ready)
    else $error("input stalled with empty result register");

  a_no_scan_when_done: assert property (@(posedge clk) disable iff (rst)
    (proc && scan_done && s_kind != wbps_pkg::KIND_RESTART) |=>
      (scan_done && $stable(partial) && $stable(scan_position)))
    else $error("scan state moved after a result");

endmodule
